### hdl/cau_pkg.sv
// Shared constants, codes and stage payload types for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 16;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_REAL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IMAG = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CONJ = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_MOD  = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV0 = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    localparam int PROD_W   = 2 * DATA_W;          // one 16x16 product
    localparam int SUM_W    = PROD_W + 1;          // sum of two products
    localparam int SIMPLE_W = DATA_W + 1;          // add/sub/negate result
    localparam int DIR_W    = SUM_W - FRAC_BITS;   // rounded product sum
    localparam int NUM_W    = SUM_W + FRAC_BITS + 1; // 2*num*2^F + den
    localparam int MAG_W    = NUM_W - 1;           // |numerator|
    localparam int DEN_W    = PROD_W + 1;          // 2*den
    localparam int QUO_W    = DATA_W + 2;          // quotient bits incl. overflow bit
    localparam int CMP_W    = DEN_W + QUO_W - 1;   // widest shifted divisor
    localparam int ROOT_W   = DATA_W;
    localparam int STEPS    = QUO_W;

    localparam logic [DATA_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 16'h8000;

    // payload carried through the divide / root steps
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [DIR_W-1:0] dir_re;
        logic signed [DIR_W-1:0] dir_im;
        logic                    neg_re;
        logic                    neg_im;
        logic                    den_zero;
        logic [DEN_W-1:0]        d;
        logic [MAG_W-1:0]        rem_re;
        logic [MAG_W-1:0]        rem_im;
        logic [QUO_W-1:0]        q_re;
        logic [QUO_W-1:0]        q_im;
        logic [PROD_W-1:0]       sq_rem;
        logic [ROOT_W-1:0]       sq_root;
    } iter_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_t;

endpackage

### hdl/cau_front.sv
// Front end: products, product sums and numerator magnitudes (three stages).
// Depends on cau_pkg.
module cau_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cau_pkg::KIND_W-1:0]    in_kind,
    input  logic signed [cau_pkg::DATA_W-1:0] in_ar,
    input  logic signed [cau_pkg::DATA_W-1:0] in_ai,
    input  logic signed [cau_pkg::DATA_W-1:0] in_br,
    input  logic signed [cau_pkg::DATA_W-1:0] in_bi,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cau_pkg::iter_t                out_data
);
    import cau_pkg::*;

    logic rdy1, rdy2, rdy3;

    // stage 1: products and simple results
    logic                      s1_valid_reg;
    logic [KIND_W-1:0]         s1_kind_reg;
    logic signed [PROD_W-1:0]  s1_rr_reg, s1_ii_reg, s1_ir_reg, s1_ri_reg;
    logic signed [PROD_W-1:0]  s1_aa_reg, s1_ai_reg, s1_bb_reg, s1_bi_reg;
    logic signed [SIMPLE_W-1:0] s1_sre_reg, s1_sim_reg;
    logic signed [SIMPLE_W-1:0] sre_next, sim_next;
    logic signed [SIMPLE_W-1:0] ar_x, ai_x, br_x, bi_x;

    assign ar_x = SIMPLE_W'(in_ar);
    assign ai_x = SIMPLE_W'(in_ai);
    assign br_x = SIMPLE_W'(in_br);
    assign bi_x = SIMPLE_W'(in_bi);

    always_comb begin
        sre_next = '0;
        sim_next = '0;
        case (in_kind)
            KIND_REAL: sre_next = ar_x;
            KIND_IMAG: sre_next = ai_x;
            KIND_CONJ: begin
                sre_next = ar_x;
                sim_next = -ai_x;
            end
            KIND_ADD: begin
                sre_next = ar_x + br_x;
                sim_next = ai_x + bi_x;
            end
            KIND_SUB: begin
                sre_next = ar_x - br_x;
                sim_next = ai_x - bi_x;
            end
            default: begin
                sre_next = '0;
                sim_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (rdy1) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            s1_kind_reg <= in_kind;
            s1_rr_reg   <= in_ar * in_br;
            s1_ii_reg   <= in_ai * in_bi;
            s1_ir_reg   <= in_ai * in_br;
            s1_ri_reg   <= in_ar * in_bi;
            s1_aa_reg   <= in_ar * in_ar;
            s1_ai_reg   <= in_ai * in_ai;
            s1_bb_reg   <= in_br * in_br;
            s1_bi_reg   <= in_bi * in_bi;
            s1_sre_reg  <= sre_next;
            s1_sim_reg  <= sim_next;
        end
    end

    // stage 2: product sums, rounding of the multiply, division numerators
    logic                      s2_valid_reg;
    logic [KIND_W-1:0]         s2_kind_reg;
    logic signed [DIR_W-1:0]   s2_dre_reg, s2_dim_reg;
    logic signed [NUM_W-1:0]   s2_nre_reg, s2_nim_reg;
    logic [PROD_W-1:0]         s2_den_reg, s2_v_reg;

    logic signed [SUM_W-1:0]   mre, mim, nr, ni;
    logic signed [SUM_W:0]     mre_rnd, mim_rnd;
    logic signed [DIR_W-1:0]   dre_next, dim_next;
    logic [PROD_W-1:0]         den_next, v_next;
    logic signed [NUM_W-1:0]   nre_next, nim_next;

    always_comb begin
        mre     = SUM_W'(s1_rr_reg) - SUM_W'(s1_ii_reg);
        mim     = SUM_W'(s1_ir_reg) + SUM_W'(s1_ri_reg);
        mre_rnd = (SUM_W+1)'(mre) + (SUM_W+1)'(1 << (FRAC_BITS - 1));
        mim_rnd = (SUM_W+1)'(mim) + (SUM_W+1)'(1 << (FRAC_BITS - 1));
        if (s1_kind_reg == KIND_MUL) begin
            dre_next = mre_rnd[FRAC_BITS+DIR_W-1:FRAC_BITS];
            dim_next = mim_rnd[FRAC_BITS+DIR_W-1:FRAC_BITS];
        end else begin
            dre_next = DIR_W'(s1_sre_reg);
            dim_next = DIR_W'(s1_sim_reg);
        end
        nr       = SUM_W'(s1_rr_reg) + SUM_W'(s1_ii_reg);
        ni       = SUM_W'(s1_ir_reg) - SUM_W'(s1_ri_reg);
        den_next = s1_bb_reg + s1_bi_reg;
        v_next   = s1_aa_reg + s1_ai_reg;
        nre_next = {nr, {(FRAC_BITS+1){1'b0}}} + NUM_W'(den_next);
        nim_next = {ni, {(FRAC_BITS+1){1'b0}}} + NUM_W'(den_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (rdy2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_valid_reg) begin
            s2_kind_reg <= s1_kind_reg;
            s2_dre_reg  <= dre_next;
            s2_dim_reg  <= dim_next;
            s2_nre_reg  <= nre_next;
            s2_nim_reg  <= nim_next;
            s2_den_reg  <= den_next;
            s2_v_reg    <= v_next;
        end
    end

    // stage 3: sign / magnitude split of the numerators
    logic  s3_valid_reg;
    iter_t s3_data_reg;
    iter_t s3_next;
    logic signed [NUM_W-1:0] nre_abs, nim_abs;

    always_comb begin
        nre_abs = s2_nre_reg[NUM_W-1] ? -s2_nre_reg : s2_nre_reg;
        nim_abs = s2_nim_reg[NUM_W-1] ? -s2_nim_reg : s2_nim_reg;
        s3_next          = '0;
        s3_next.kind     = s2_kind_reg;
        s3_next.dir_re   = s2_dre_reg;
        s3_next.dir_im   = s2_dim_reg;
        s3_next.neg_re   = s2_nre_reg[NUM_W-1];
        s3_next.neg_im   = s2_nim_reg[NUM_W-1];
        s3_next.den_zero = (s2_den_reg == '0);
        s3_next.d        = {s2_den_reg, 1'b0};
        s3_next.rem_re   = nre_abs[MAG_W-1:0];
        s3_next.rem_im   = nim_abs[MAG_W-1:0];
        s3_next.sq_rem   = s2_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (rdy3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && s2_valid_reg) begin
            s3_data_reg <= s3_next;
        end
    end

    assign rdy3      = !s3_valid_reg || out_ready;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

### hdl/cau_iter.sv
// Pipelined restoring divider (two quotients) and digit-by-digit square root,
// one quotient bit per stage and one root bit in each stage whose bit weight is below ROOT_W. Depends on cau_pkg.
module cau_iter (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::iter_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::iter_t out_data
);
    import cau_pkg::*;

    logic  valid_reg [STEPS];
    iter_t stage_reg [STEPS];
    logic [STEPS:0] rdy;

    assign rdy[STEPS] = out_ready;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = STEPS - 1 - j;   // bit weight handled here

        iter_t src;
        logic  src_valid;
        iter_t step_next;
        logic [CMP_W-1:0] dshift, rre, rim;

        if (j == 0) begin : g_first
            assign src       = in_data;
            assign src_valid = in_valid;
        end else begin : g_rest
            assign src       = stage_reg[j-1];
            assign src_valid = valid_reg[j-1];
        end

        assign rdy[j] = !valid_reg[j] || rdy[j+1];

        always_comb begin
            step_next = src;
            dshift    = CMP_W'(src.d) << K;
            rre       = CMP_W'(src.rem_re);
            rim       = CMP_W'(src.rem_im);
            if (rre >= dshift) begin
                step_next.rem_re  = MAG_W'(rre - dshift);
                step_next.q_re[K] = 1'b1;
            end
            if (rim >= dshift) begin
                step_next.rem_im  = MAG_W'(rim - dshift);
                step_next.q_im[K] = 1'b1;
            end
        end

        if (K < ROOT_W) begin : g_root
            logic [PROD_W:0] trial;
            iter_t root_next;
            always_comb begin
                root_next = step_next;
                trial = ((PROD_W+1)'(src.sq_root) << (K + 1))
                      + ((PROD_W+1)'(1) << (2 * K));
                if ({1'b0, src.sq_rem} >= trial) begin
                    root_next.sq_rem     = src.sq_rem - trial[PROD_W-1:0];
                    root_next.sq_root[K] = 1'b1;
                end
            end
            always_ff @(posedge aclk) begin
                if (rdy[j] && src_valid) begin
                    stage_reg[j] <= root_next;
                end
            end
        end else begin : g_noroot
            always_ff @(posedge aclk) begin
                if (rdy[j] && src_valid) begin
                    stage_reg[j] <= step_next;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                valid_reg[j] <= src_valid;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STEPS-1];
    assign out_data  = stage_reg[STEPS-1];

endmodule

### hdl/cau_back.sv
// Back end: quotient sign fix-up, root rounding, saturation, status and
// the output register. Depends on cau_pkg.
module cau_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cau_pkg::iter_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cau_pkg::DATA_W-1:0]     out_real,
    output logic [cau_pkg::DATA_W-1:0]     out_imag,
    output logic [cau_pkg::STATUS_W-1:0]   out_status
);
    import cau_pkg::*;

    // floor quotient from magnitude: negative side rounds away from zero
    function automatic sat_t div_fix(input logic [QUO_W-1:0] q, input logic nz,
                                     input logic neg);
        logic [QUO_W-1:0] mag;
        logic [QUO_W-1:0] neg_mag;
        sat_t r;
        mag     = {1'b0, q[QUO_W-2:0]} + QUO_W'(nz);
        neg_mag = -mag;
        r.sat   = 1'b0;
        if (neg) begin
            if (q[QUO_W-1] || mag > QUO_W'(32768)) begin
                r.val = SAT_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = neg_mag[DATA_W-1:0];
            end
        end else begin
            if (q[QUO_W-1] || q[QUO_W-2:0] > (QUO_W-1)'(32767)) begin
                r.val = SAT_MAX;
                r.sat = 1'b1;
            end else begin
                r.val = q[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic sat_t sat_dir(input logic signed [DIR_W-1:0] v);
        sat_t r;
        r.sat = 1'b1;
        if (v > DIR_W'(32767)) begin
            r.val = SAT_MAX;
        end else if (v < -DIR_W'(32768)) begin
            r.val = SAT_MIN;
        end else begin
            r.val = v[DATA_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    sat_t re_sel, im_sel;
    logic [ROOT_W:0] root_rnd;
    logic div0;
    logic [STATUS_W-1:0] status_next;

    always_comb begin
        root_rnd = {1'b0, in_data.sq_root}
                 + (ROOT_W+1)'(in_data.sq_rem > PROD_W'(in_data.sq_root));
        div0     = 1'b0;
        case (in_data.kind)
            KIND_DIV: begin
                if (in_data.den_zero) begin
                    div0   = 1'b1;
                    re_sel = '0;
                    im_sel = '0;
                end else begin
                    re_sel = div_fix(in_data.q_re, in_data.rem_re != '0, in_data.neg_re);
                    im_sel = div_fix(in_data.q_im, in_data.rem_im != '0, in_data.neg_im);
                end
            end
            KIND_MOD: begin
                im_sel = '0;
                if (root_rnd > (ROOT_W+1)'(32767)) begin
                    re_sel.val = SAT_MAX;
                    re_sel.sat = 1'b1;
                end else begin
                    re_sel.val = root_rnd[DATA_W-1:0];
                    re_sel.sat = 1'b0;
                end
            end
            default: begin
                re_sel = sat_dir(in_data.dir_re);
                im_sel = sat_dir(in_data.dir_im);
            end
        endcase
        if (div0) begin
            status_next = STATUS_DIV0;
        end else if (re_sel.sat || im_sel.sat) begin
            status_next = STATUS_SAT;
        end else begin
            status_next = STATUS_OK;
        end
    end

    logic                valid_reg;
    logic [DATA_W-1:0]   real_reg, imag_reg;
    logic [STATUS_W-1:0] status_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            real_reg   <= re_sel.val;
            imag_reg   <= im_sel.val;
            status_reg <= status_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_real   = real_reg;
    assign out_imag   = imag_reg;
    assign out_status = status_reg;

endmodule

### hdl/complex_arithmetic_unit_top.sv
// Complex arithmetic unit, Q8.8: an input transfer passes 3 front stages, 18 divide/root
// steps and 1 output register on the way to its result; one transfer per cycle unless stalled.
// Throughput is one item per cycle while m_tready stays high; the 18-step divide/root pipeline is the deepest part.
// Each stage stalls only when full and its successor is blocked, so bubbles collapse.
// aresetn (synchronous, active low) empties the pipeline; no results are pending after.
// Depends on cau_pkg, cau_front, cau_iter, cau_back.
module complex_arithmetic_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_real[15:0], a_imag[31:16], b_real[47:32], b_imag[63:48]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // out_real[15:0], out_imag[31:16], status[33:32], zero[39:34]
);
    import cau_pkg::*;

    logic  f_valid, f_ready;
    iter_t f_data;
    logic  i_valid, i_ready;
    iter_t i_data;
    logic [DATA_W-1:0]   res_real, res_imag;
    logic [STATUS_W-1:0] res_status;

    // products, sums, numerator magnitudes
    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_ar     (s_tdata[15:0]),
        .in_ai     (s_tdata[31:16]),
        .in_br     (s_tdata[47:32]),
        .in_bi     (s_tdata[63:48]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    // one quotient bit per stage, and one root bit per stage whose bit weight is below ROOT_W
    cau_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (i_valid),
        .out_ready (i_ready),
        .out_data  (i_data)
    );

    // rounding, saturation, status, output register
    cau_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (i_valid),
        .in_ready   (i_ready),
        .in_data    (i_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_real   (res_real),
        .out_imag   (res_imag),
        .out_status (res_status)
    );

    assign m_tdata = {6'b0, res_status, res_imag, res_real};

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for complex_arithmetic_unit_top: directed and random operations,
// predicted in place and compared with every result transfer. Depends on cau_pkg.
module testbench;
    import cau_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [15:0] ar, ai, br, bi;
    } op_t;

    typedef struct packed {
        logic [15:0] re, im;
        logic [STATUS_W-1:0] st;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    complex_arithmetic_unit_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    op_t  pending_ops[$];
    res_t expected_results[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors = 0;
    int   sent = 0;
    int   received = 0;
    bit   stim_done = 0;
    bit   s_accepted = 0;

    // floor division, positive divisor
    function automatic longint fdiv(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic logic [15:0] clamp16(longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1; return 16'h7FFF;
        end
        if (v < -32768) begin
            sat = 1; return 16'h8000;
        end
        return v[15:0];
    endfunction

    // rounded integer square root
    function automatic longint root_round(longint v);
        longint r, t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic res_t compute_result(op_t op);
        longint ar, ai, br, bi, re, im, den, nr, ni;
        bit sat;
        res_t r;
        ar = longint'($signed(op.ar));
        ai = longint'($signed(op.ai));
        br = longint'($signed(op.br));
        bi = longint'($signed(op.bi));
        re = 0; im = 0; sat = 0;
        r.st = STATUS_OK;
        case (op.kind)
            KIND_REAL: re = ar;
            KIND_IMAG: re = ai;
            KIND_CONJ: begin
                re = ar; im = -ai;
            end
            KIND_ADD: begin
                re = ar + br; im = ai + bi;
            end
            KIND_SUB: begin
                re = ar - br; im = ai - bi;
            end
            KIND_MUL: begin
                re = fdiv(ar * br - ai * bi + (1 << (FRAC_BITS - 1)), 1 << FRAC_BITS);
                im = fdiv(ai * br + ar * bi + (1 << (FRAC_BITS - 1)), 1 << FRAC_BITS);
            end
            KIND_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) r.st = STATUS_DIV0;
                else begin
                    nr = (ar * br + ai * bi) * (1 << FRAC_BITS);
                    ni = (ai * br - ar * bi) * (1 << FRAC_BITS);
                    re = fdiv(2 * nr + den, 2 * den);
                    im = fdiv(2 * ni + den, 2 * den);
                end
            end
            default: re = root_round(ar * ar + ai * ai);
        endcase
        r.re = clamp16(re, sat);
        r.im = clamp16(im, sat);
        if (r.st == STATUS_OK && sat) r.st = STATUS_SAT;
        return r;
    endfunction

    function automatic op_t mk(logic [2:0] k, logic [15:0] a, logic [15:0] b,
                               logic [15:0] c, logic [15:0] d);
        op_t o;
        o.kind = k; o.ar = a; o.ai = b; o.br = c; o.bi = d;
        return o;
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // driver: offer the next pending op, idle at random, at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_accepted) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    op_t o;
                    o = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= o.kind;
                    s_tdata  <= {o.bi, o.br, o.ai, o.ar};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on input transfers, check on result transfers
    always @(posedge aclk) begin
        s_accepted = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                op_t o;
                s_accepted = 1'b1;
                o = mk(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                       s_tdata[63:48]);
                expected_results.push_back(compute_result(o));
                sent++;
            end
            if (m_tvalid && m_tready) begin
                res_t e;
                received++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_tdata);
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[15:0] !== e.re) begin
                        errors++;
                        $display("%0t: out_real expected %h actual %h", $time, e.re,
                                 m_tdata[15:0]);
                    end
                    if (m_tdata[31:16] !== e.im) begin
                        errors++;
                        $display("%0t: out_imag expected %h actual %h", $time, e.im,
                                 m_tdata[31:16]);
                    end
                    if (m_tdata[33:32] !== e.st) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, e.st,
                                 m_tdata[33:32]);
                    end
                end
            end
        end
    end

    task automatic random_ops(int n);
        for (int i = 0; i < n; i++) begin
            op_t o;
            o = mk(3'($urandom_range(0, 7)), rand_val(), rand_val(), rand_val(), rand_val());
            if ($urandom_range(0, 15) == 0) begin
                o.kind = KIND_DIV; o.br = '0; o.bi = '0;
            end
            pending_ops.push_back(o);
        end
    endtask

    task automatic drain();
        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        // directed: each operation at the extremes, divide by zero, conjugate of min
        for (int k = 0; k < 8; k++) begin
            pending_ops.push_back(mk(3'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000));
            pending_ops.push_back(mk(3'(k), 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
        end
        pending_ops.push_back(mk(KIND_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000));
        pending_ops.push_back(mk(KIND_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000));
        pending_ops.push_back(mk(KIND_DIV, 16'h0300, 16'hFF00, 16'h0100, 16'h0100));
        pending_ops.push_back(mk(KIND_MUL, 16'h0180, 16'hFF80, 16'h0080, 16'h0080));
        pending_ops.push_back(mk(KIND_MOD, 16'h0300, 16'h0400, 16'h0000, 16'h0000));
        pending_ops.push_back(mk(KIND_CONJ, 16'h0001, 16'h8000, 16'h0000, 16'h0000));
        pending_ops.push_back(mk(KIND_ADD, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF));
        send_idle_pct = 24; recv_idle_pct = 87;
        random_ops(250);
        drain();
        send_idle_pct = 87; recv_idle_pct = 24;
        random_ops(250);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_ops(250);
        drain();
        repeat (40) @(posedge aclk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("covered %0d operations over all kinds, %0d results checked", sent, received);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("testbench failed");
        $finish;
    end
endmodule

### filelist.f
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_iter.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit_top.sv
tb/sv/testbench.sv
